/* hw/rtl/tfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tfb_pkg;

  localparam int DISPLAY_WIDTH = 128;
  localparam int DISPLAY_PAGES = 8;
  localparam int STORE_DEPTH   = DISPLAY_WIDTH * DISPLAY_PAGES;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int POS_W         = $clog2(DISPLAY_WIDTH + 3);

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_DRAW    = 2'd1;
  localparam logic [1:0] MODE_STRING  = 2'd2;
  localparam logic [1:0] MODE_REFRESH = 2'd3;

  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;

  localparam logic [2:0] GLYPH_COLS = 3'd5;
  localparam logic [2:0] CELL_LAST  = 3'd5;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_OUT
  } state_t;

  function automatic logic [5:0] glyph_of(input logic [7:0] c);
    logic [5:0] g;
    g = 6'd0;
    if (c >= 8'h30 && c <= 8'h39) g = 6'(c - 8'h30) + 6'd1;
    else if (c >= 8'h41 && c <= 8'h5A) g = 6'(c - 8'h41) + 6'd11;
    else if (c >= 8'h61 && c <= 8'h7A) g = 6'(c - 8'h61) + 6'd11;
    else if (c == 8'h21) g = 6'd37;
    else if (c == 8'h3F) g = 6'd38;
    else if (c == 8'h3C) g = 6'd39;
    else if (c == 8'h3E) g = 6'd40;
    else if (c == 8'h2E) g = 6'd41;
    else if (c == 8'h2C) g = 6'd42;
    return g;
  endfunction

  function automatic logic [39:0] glyph_row(input logic [5:0] g);
    logic [39:0] r;
    case (g)
      6'd1:  r = 40'h3E_51_49_45_3E;
      6'd2:  r = 40'h00_42_7F_40_00;
      6'd3:  r = 40'h42_61_51_49_46;
      6'd4:  r = 40'h21_41_45_4B_31;
      6'd5:  r = 40'h18_14_12_7F_10;
      6'd6:  r = 40'h27_45_45_45_39;
      6'd7:  r = 40'h3C_4A_49_49_30;
      6'd8:  r = 40'h01_71_09_05_03;
      6'd9:  r = 40'h36_49_49_49_36;
      6'd10: r = 40'h06_49_49_29_1E;
      6'd11: r = 40'h7E_09_09_09_7E;
      6'd12: r = 40'h7F_49_49_49_36;
      6'd13: r = 40'h3E_41_41_41_22;
      6'd14: r = 40'h7F_41_41_22_1C;
      6'd15: r = 40'h7F_49_49_49_41;
      6'd16: r = 40'h7F_09_09_09_01;
      6'd17: r = 40'h3E_41_49_49_7A;
      6'd18: r = 40'h7F_08_08_08_7F;
      6'd19: r = 40'h00_41_7F_41_00;
      6'd20: r = 40'h20_40_41_3F_01;
      6'd21: r = 40'h7F_08_14_22_41;
      6'd22: r = 40'h7F_40_40_40_40;
      6'd23: r = 40'h7F_02_0C_02_7F;
      6'd24: r = 40'h7F_04_08_10_7F;
      6'd25: r = 40'h3E_41_41_41_3E;
      6'd26: r = 40'h7F_09_09_09_06;
      6'd27: r = 40'h3E_41_51_21_5E;
      6'd28: r = 40'h7F_09_19_29_46;
      6'd29: r = 40'h46_49_49_49_31;
      6'd30: r = 40'h01_01_7F_01_01;
      6'd31: r = 40'h3F_40_40_40_3F;
      6'd32: r = 40'h1F_20_40_20_1F;
      6'd33: r = 40'h7F_20_18_20_7F;
      6'd34: r = 40'h63_14_08_14_63;
      6'd35: r = 40'h07_08_70_08_07;
      6'd36: r = 40'h61_51_49_45_43;
      6'd37: r = 40'h00_00_5F_00_00;
      6'd38: r = 40'h02_01_51_09_06;
      6'd39: r = 40'h08_14_22_41_00;
      6'd40: r = 40'h41_22_14_08_00;
      6'd41: r = 40'h00_40_30_00_00;
      6'd42: r = 40'h00_60_20_00_00;
      default: r = 40'h00_00_00_00_00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_byte(input logic [5:0] g, input logic [2:0] i);
    logic [39:0] r;
    logic [7:0] b;
    r = glyph_row(g);
    case (i)
      3'd0: b = r[39:32];
      3'd1: b = r[31:24];
      3'd2: b = r[23:16];
      3'd3: b = r[15:8];
      3'd4: b = r[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tfb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module tfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* hw/rtl/text_framebuffer_display_refresh.sv */
`timescale 1ns / 1ps
`default_nettype none
// Text frame buffer with a byte-serial display refresh stream.
// Items enter on start while busy is low: mode selects clear, draw at a
// column and page, string character at the text cursor (first_of_string sets
// it from column and page), or refresh tick. Only a refresh tick gives a
// result: out_byte, is_data, ends_transfer, frame_last, held for exactly one
// cycle with strobe high, in the cycle after the tick is taken (store read is registered).
// Store work per item on the single-port frame store:
//   draw / string character: six store write steps, one cell column
//   each (writes off the display are skipped); halted string character: none
//   refresh tick: accept, then result cycle
//   clear: all DISPLAY_WIDTH*DISPLAY_PAGES entries (1024 at 128x8), one
//   store entry zeroed per cycle
// After reset the same clearing pass runs with busy high; cursor and refresh
// counters reset to zero. Results cannot be held off by the receiver; each
// is taken in its strobe cycle.
module text_framebuffer_display_refresh (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] column,
  input  wire logic [2:0] page_row,
  input  wire logic       first_of_string,
  input  wire logic [7:0] char_code,
  output logic            strobe,
  output logic      [7:0] out_byte,
  output logic            is_data,
  output logic            ends_transfer,
  output logic            frame_last
);

  tfb_pkg::state_t state, state_next;

  logic                       accept;
  logic [tfb_pkg::ADDR_W-1:0] clr_addr;
  logic                       clr_done;

  logic [8:0] draw_col;
  logic [3:0] draw_page;
  logic [5:0] draw_glyph;
  logic [2:0] step;
  logic [8:0] draw_x;
  logic       draw_hit;

  logic [7:0] cursor_column;
  logic [3:0] cursor_page;
  logic       string_halted;

  logic [2:0]              refresh_page;
  logic [tfb_pkg::POS_W-1:0] refresh_position;
  logic [tfb_pkg::POS_W-1:0] ref_col;

  logic [7:0] cmd_byte;
  logic       data_sel;
  logic       ends_r;
  logic       last_r;

  logic                       ram_we;
  logic [tfb_pkg::ADDR_W-1:0] ram_addr;
  logic [7:0]                 ram_wdata;
  logic [7:0]                 ram_rdata;

  logic [7:0] s_col;
  logic [3:0] s_page;
  logic       s_halt;
  logic [8:0] s_next;
  logic [3:0] s_page_inc;

  assign accept   = start && !busy;
  assign clr_done = (clr_addr == tfb_pkg::ADDR_W'(tfb_pkg::STORE_DEPTH - 1));
  assign draw_x   = draw_col + 9'(step);
  assign draw_hit = (draw_page < 4'(tfb_pkg::DISPLAY_PAGES)) &&
                    (draw_x < 9'(tfb_pkg::DISPLAY_WIDTH));
  assign ref_col  = refresh_position - tfb_pkg::POS_W'(3);

  // effective cursor for a string character
  always_comb begin
    s_col  = first_of_string ? column : cursor_column;
    s_page = first_of_string ? {1'b0, page_row} : cursor_page;
    s_halt = first_of_string ? 1'b0 : string_halted;
    s_next = {1'b0, s_col} + 9'd6;
    s_page_inc = s_page + 4'd1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tfb_pkg::ST_CLEAR: begin
        if (clr_done) state_next = tfb_pkg::ST_IDLE;
      end
      tfb_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode)
            tfb_pkg::MODE_CLEAR:   state_next = tfb_pkg::ST_CLEAR;
            tfb_pkg::MODE_DRAW:    state_next = tfb_pkg::ST_DRAW;
            tfb_pkg::MODE_STRING:  state_next = s_halt ? tfb_pkg::ST_IDLE : tfb_pkg::ST_DRAW;
            tfb_pkg::MODE_REFRESH: state_next = tfb_pkg::ST_OUT;
            default:               state_next = tfb_pkg::ST_IDLE;
          endcase
        end
      end
      tfb_pkg::ST_DRAW: begin
        if (step == tfb_pkg::CELL_LAST) state_next = tfb_pkg::ST_IDLE;
      end
      tfb_pkg::ST_OUT: begin
        state_next = tfb_pkg::ST_IDLE;
      end
      default: state_next = tfb_pkg::ST_IDLE;
    endcase
  end

  // outputs and store port
  always_comb begin
    busy      = (state != tfb_pkg::ST_IDLE);
    strobe    = (state == tfb_pkg::ST_OUT);
    ram_we    = 1'b0;
    ram_wdata = 8'h00;
    ram_addr  = tfb_pkg::ADDR_W'(int'(refresh_page) * tfb_pkg::DISPLAY_WIDTH + int'(ref_col));
    case (state)
      tfb_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      tfb_pkg::ST_DRAW: begin
        ram_we    = draw_hit;
        ram_wdata = (step < tfb_pkg::GLYPH_COLS) ? tfb_pkg::glyph_byte(draw_glyph, step) : 8'h00;
        ram_addr  = tfb_pkg::ADDR_W'(int'(draw_page) * tfb_pkg::DISPLAY_WIDTH + int'(draw_x));
      end
      default: begin
      end
    endcase
    out_byte      = data_sel ? ram_rdata : cmd_byte;
    is_data       = data_sel;
    ends_transfer = ends_r;
    frame_last    = last_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tfb_pkg::ST_CLEAR;
      clr_addr         <= '0;
      step             <= '0;
      cursor_column    <= '0;
      cursor_page      <= '0;
      string_halted    <= 1'b0;
      refresh_page     <= '0;
      refresh_position <= '0;
    end else begin
      state <= state_next;
      if (state == tfb_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + tfb_pkg::ADDR_W'(1);
      end
      if (state == tfb_pkg::ST_DRAW) begin
        step <= step + 3'd1;
      end
      if (accept) begin
        step     <= '0;
        clr_addr <= '0;
        case (mode)
          tfb_pkg::MODE_DRAW: begin
            draw_col   <= {1'b0, column};
            draw_page  <= {1'b0, page_row};
            draw_glyph <= tfb_pkg::glyph_of(char_code);
          end
          tfb_pkg::MODE_STRING: begin
            draw_col   <= {1'b0, s_col};
            draw_page  <= s_page;
            draw_glyph <= tfb_pkg::glyph_of(char_code);
            if (!s_halt) begin
              if (s_next > 9'(tfb_pkg::DISPLAY_WIDTH - 6)) begin
                cursor_column <= '0;
                cursor_page   <= s_page_inc;
                string_halted <= (s_page_inc >= 4'(tfb_pkg::DISPLAY_PAGES));
              end else begin
                cursor_column <= s_next[7:0];
                cursor_page   <= s_page;
                string_halted <= 1'b0;
              end
            end
          end
          tfb_pkg::MODE_REFRESH: begin
            last_r <= 1'b0;
            if (refresh_position == tfb_pkg::POS_W'(0)) begin
              cmd_byte         <= tfb_pkg::CMD_PAGE | {5'd0, refresh_page};
              data_sel         <= 1'b0;
              ends_r           <= 1'b1;
              refresh_position <= tfb_pkg::POS_W'(1);
            end else if (refresh_position == tfb_pkg::POS_W'(1)) begin
              cmd_byte         <= tfb_pkg::CMD_COL_LO;
              data_sel         <= 1'b0;
              ends_r           <= 1'b1;
              refresh_position <= tfb_pkg::POS_W'(2);
            end else if (refresh_position == tfb_pkg::POS_W'(2)) begin
              cmd_byte         <= tfb_pkg::CMD_COL_HI;
              data_sel         <= 1'b0;
              ends_r           <= 1'b1;
              refresh_position <= tfb_pkg::POS_W'(3);
            end else begin
              cmd_byte <= 8'h00;
              data_sel <= 1'b1;
              if (ref_col == tfb_pkg::POS_W'(tfb_pkg::DISPLAY_WIDTH - 1)) begin
                ends_r           <= 1'b1;
                last_r           <= (refresh_page == 3'(tfb_pkg::DISPLAY_PAGES - 1));
                refresh_position <= '0;
                refresh_page     <= (refresh_page == 3'(tfb_pkg::DISPLAY_PAGES - 1)) ?
                                    3'd0 : refresh_page + 3'd1;
              end else begin
                ends_r           <= 1'b0;
                refresh_position <= refresh_position + tfb_pkg::POS_W'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  tfb_ram #(
    .WIDTH(8),
    .DEPTH(tfb_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  a_strobe_from_tick: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept && mode == tfb_pkg::MODE_REFRESH))
    else $error("result without a refresh tick transfer");

  a_last_is_data_end: assert property (@(posedge clk) disable iff (rst)
    strobe && frame_last |-> is_data && ends_transfer)
    else $error("frame end on a byte that does not close a page");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == tfb_pkg::ST_CLEAR || state == tfb_pkg::ST_DRAW))
    else $error("store write outside clear or draw");

  a_draw_steps: assert property (@(posedge clk) disable iff (rst)
    state == tfb_pkg::ST_DRAW |-> step <= tfb_pkg::CELL_LAST)
    else $error("draw ran past its cell");

endmodule
`default_nettype wire
